// File: rtl/core/ucm_pkg.sv
// ============================================================================
// ucm_pkg: shared types and constants of the unified camera model projector
// Holds the cell state types, the register index codes and fixed constants.
// ============================================================================
package ucm_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;

   localparam logic [16:0] ALPHA_ONE  = 17'd65536;
   localparam logic [16:0] ALPHA_HALF = 17'd32768;

   localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_FOCAL_X = 3'd0,
      REG_FOCAL_Y = 3'd1,
      REG_CENTER_X = 3'd2,
      REG_CENTER_Y = 3'd3,
      REG_MODEL_ALPHA = 3'd4
   } ucm_reg_type;

   // Square root cell state: radicand bits still to shift in, partial
   // remainder and partial root.
   typedef struct packed {
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } ucm_sqrt_type;

   // Divider cell state: partial remainder, quotient so far and the low
   // dividend bits still to shift in.
   typedef struct packed {
      logic [49:0] rem;
      logic [31:0] quo;
      logic [31:0] low;
   } ucm_div_type;

endpackage

// File: rtl/core/ucm_sqrt_cell.sv
// ============================================================================
// ucm_sqrt_cell: one digit of the integer square root
// Resolves one root bit per cell and registers the updated state.
// ============================================================================
module ucm_sqrt_cell
   import ucm_pkg::*;
(
   input  logic         clock,
   input  ucm_sqrt_type cell_in,
   output ucm_sqrt_type cell_ff
);

   ucm_sqrt_type cell_in_next;
   logic [34:0]  rem_sh;
   logic [34:0]  trial;

   always_comb begin
      rem_sh = {cell_in.rem[32:0], cell_in.rad[63:62]};
      trial  = {1'b0, cell_in.root, 2'b01};
      cell_in_next.rad = {cell_in.rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in_next.rem  = rem_sh - trial;
         cell_in_next.root = {cell_in.root[30:0], 1'b1};
      end else begin
         cell_in_next.rem  = rem_sh;
         cell_in_next.root = {cell_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

endmodule

// File: rtl/core/ucm_div_cell.sv
// ============================================================================
// ucm_div_cell: one step of the restoring divider
// Produces one quotient bit per cell against the shared denominator.
// ============================================================================
module ucm_div_cell
   import ucm_pkg::*;
(
   input  logic        clock,
   input  ucm_div_type cell_in,
   input  logic [49:0] den,
   output ucm_div_type cell_ff
);

   ucm_div_type cell_in_next;
   logic [50:0] rem_sh;

   always_comb begin
      rem_sh = {cell_in.rem, cell_in.low[31]};
      cell_in_next.low = {cell_in.low[30:0], 1'b0};
      if (rem_sh >= {1'b0, den}) begin
         cell_in_next.rem = 50'(rem_sh - {1'b0, den});
         cell_in_next.quo = {cell_in.quo[30:0], 1'b1};
      end else begin
         cell_in_next.rem = rem_sh[49:0];
         cell_in_next.quo = {cell_in.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

endmodule

// File: rtl/core/ucm_fisheye_project.sv
// ============================================================================
// ucm_fisheye_project: unified camera model point projection
// Projects one signed fixed-point 3D point per clock, while busy is low, to pixel coordinates.
// ============================================================================
// The block takes one point per clock while busy is low and returns one
// result per point, in order. It is built from two chains of cells: 32
// cells that resolve the square root of the squared length one bit each,
// and 32 cells that resolve the quotient of the perspective division one
// bit each, plus eight stages: input, squares, sum, alpha products,
// denominator test, focal products, overflow check and final sign, center
// offset and saturation. The receiver cannot stall, so rsp_valid is a
// strobe of one cycle for each result. busy is high during reset and in
// the cycle after it. Configuration registers are read live by the
// pipeline, so they may only be written while no point is in flight.
// ============================================================================
module ucm_fisheye_project
   import ucm_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Point input.
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_ray_x,
   input  logic [31:0] req_ray_y,
   input  logic [31:0] req_ray_z,
   // Projection result.
   output logic        rsp_valid,
   output logic        rsp_proj_valid,
   output logic [31:0] rsp_pixel_u,
   output logic [31:0] rsp_pixel_v,
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Smallest denominator that passes the 1e-3 test, scaled by 2^(F+16).
   localparam logic [63:0] DEN_MIN_WIDE = ((64'd1 << (FRAC_BITS + 16)) + 64'd999) / 64'd1000;
   localparam logic [49:0] DEN_MIN      = DEN_MIN_WIDE[49:0];
   // Minus one in the pixel format.
   localparam logic [31:0] INVALID_PIX  = ~((32'd1 << FRAC_BITS) - 32'd1);
   localparam int          LATENCY      = 72;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef struct packed {
      logic        ok;
      logic        sx;
      logic        sy;
      logic        ovfx;
      logic        ovfy;
      logic [49:0] den;
   } div_side_type;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [31:0] focal_x_ff, focal_y_ff;
   logic [31:0] center_x_ff, center_y_ff;
   logic [16:0] alpha_ff;
   logic        busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= '0;
         focal_y_ff  <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         alpha_ff    <= ALPHA_HALF;
         busy_ff     <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (ucm_reg_type'(csr_index))
               REG_FOCAL_X:     focal_x_ff  <= csr_wdata;
               REG_FOCAL_Y:     focal_y_ff  <= csr_wdata;
               REG_CENTER_X:    center_x_ff <= csr_wdata;
               REG_CENTER_Y:    center_y_ff <= csr_wdata;
               REG_MODEL_ALPHA: alpha_ff    <= csr_wdata[16:0];
               default: ;
            endcase
         end
      end
   end

   // Alpha above one is treated as one.
   logic [16:0] alpha_a;
   logic [16:0] alpha_ia;
   assign alpha_a  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign alpha_ia = 17'(ALPHA_ONE - alpha_a);

   // ---------------------------------------------------------------------
   // Input register, squares and the sum of squares.
   // ---------------------------------------------------------------------
   logic        a_vld_ff, b_vld_ff, c_vld_ff;
   point_type   a_pt_ff, b_pt_ff, c_pt_ff;
   logic [63:0] b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [63:0] b_sqx_in, b_sqy_in, b_sqz_in;
   logic [31:0] a_mx, a_my, a_mz;
   logic [63:0] c_sum_ff;

   always_comb begin
      a_mx = a_pt_ff.x[31] ? 32'(~a_pt_ff.x + 32'd1) : a_pt_ff.x;
      a_my = a_pt_ff.y[31] ? 32'(~a_pt_ff.y + 32'd1) : a_pt_ff.y;
      a_mz = a_pt_ff.z[31] ? 32'(~a_pt_ff.z + 32'd1) : a_pt_ff.z;
      b_sqx_in = 64'(a_mx) * 64'(a_mx);
      b_sqy_in = 64'(a_my) * 64'(a_my);
      b_sqz_in = 64'(a_mz) * 64'(a_mz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy_ff;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_pt_ff  <= '{x: req_ray_x, y: req_ray_y, z: req_ray_z};
      b_pt_ff  <= a_pt_ff;
      b_sqx_ff <= b_sqx_in;
      b_sqy_ff <= b_sqy_in;
      b_sqz_ff <= b_sqz_in;
      c_pt_ff  <= b_pt_ff;
      c_sum_ff <= b_sqx_ff + b_sqy_ff + b_sqz_ff;
   end

   // ---------------------------------------------------------------------
   // Square root chain: one root bit per cell, point carried alongside.
   // ---------------------------------------------------------------------
   ucm_sqrt_type sq_in [SQRT_STEPS];
   ucm_sqrt_type sq_ff [SQRT_STEPS];
   point_type    sside_ff [SQRT_STEPS];
   logic         svld_ff  [SQRT_STEPS];

   genvar gs;
   generate
      for (gs = 0; gs < SQRT_STEPS; gs++) begin : g_sqrt
         if (gs == 0) begin : g_first
            assign sq_in[gs] = '{rad: c_sum_ff, rem: '0, root: '0};
         end else begin : g_next
            assign sq_in[gs] = sq_ff[gs-1];
         end
         ucm_sqrt_cell u_cell (
            .clock   (clock),
            .cell_in (sq_in[gs]),
            .cell_ff (sq_ff[gs])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      sside_ff[0] <= c_pt_ff;
      for (int k = 1; k < SQRT_STEPS; k++) begin
         sside_ff[k] <= sside_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            svld_ff[k] <= 1'b0;
         end
      end else begin
         svld_ff[0] <= c_vld_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            svld_ff[k] <= svld_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Products with alpha and one minus alpha.
   // ---------------------------------------------------------------------
   logic [31:0]        s_d;
   point_type          s_pt;
   logic               e_vld_ff;
   point_type          e_pt_ff;
   logic               e_big_ff;
   logic signed [49:0] e_ad_ff, e_iaz_ff, e_az_ff, e_iad_ff;

   assign s_d  = sq_ff[SQRT_STEPS-1].root;
   assign s_pt = sside_ff[SQRT_STEPS-1];

   always_ff @(posedge clock) begin
      e_pt_ff  <= s_pt;
      e_big_ff <= alpha_a > ALPHA_HALF;
      e_ad_ff  <= $signed({33'd0, alpha_a}) * $signed({18'd0, s_d});
      e_iad_ff <= $signed({33'd0, alpha_ia}) * $signed({18'd0, s_d});
      e_iaz_ff <= $signed({33'd0, alpha_ia}) * $signed({{18{s_pt.z[31]}}, s_pt.z});
      e_az_ff  <= $signed({33'd0, alpha_a}) * $signed({{18{s_pt.z[31]}}, s_pt.z});
   end

   // ---------------------------------------------------------------------
   // Denominator and validity test.
   // ---------------------------------------------------------------------
   logic signed [49:0] f_den_in, f_cond_in;
   logic               f_vld_ff, f_ok_ff;
   logic signed [49:0] f_den_ff;
   point_type          f_pt_ff;

   always_comb begin
      f_den_in  = e_ad_ff + e_iaz_ff;
      f_cond_in = e_big_ff ? (e_az_ff + e_iad_ff) : f_den_in;
   end

   always_ff @(posedge clock) begin
      f_pt_ff  <= e_pt_ff;
      f_den_ff <= f_den_in;
      f_ok_ff  <= !f_den_in[49] && (f_den_in >= $signed(DEN_MIN))
                  && !f_cond_in[49] && (f_cond_in != '0);
   end

   // ---------------------------------------------------------------------
   // Numerators: focal length times coordinate magnitude.
   // ---------------------------------------------------------------------
   logic        g_vld_ff, g_ok_ff, g_sx_ff, g_sy_ff;
   logic [49:0] g_den_ff;
   logic [63:0] g_nx_ff, g_ny_ff;
   logic [31:0] f_mx, f_my;

   always_comb begin
      f_mx = f_pt_ff.x[31] ? 32'(~f_pt_ff.x + 32'd1) : f_pt_ff.x;
      f_my = f_pt_ff.y[31] ? 32'(~f_pt_ff.y + 32'd1) : f_pt_ff.y;
   end

   always_ff @(posedge clock) begin
      g_ok_ff  <= f_ok_ff;
      g_sx_ff  <= f_pt_ff.x[31];
      g_sy_ff  <= f_pt_ff.y[31];
      g_den_ff <= f_den_ff;
      g_nx_ff  <= 64'(focal_x_ff) * 64'(f_mx);
      g_ny_ff  <= 64'(focal_y_ff) * 64'(f_my);
   end

   // ---------------------------------------------------------------------
   // Overflow check and divider set-up. A quotient of 2^32 or more
   // saturates whatever the center, so the dividers need only 32 bits.
   // ---------------------------------------------------------------------
   logic         h_vld_ff;
   div_side_type h_side_ff;
   ucm_div_type  h_dx_ff, h_dy_ff;

   always_ff @(posedge clock) begin
      h_side_ff.ok   <= g_ok_ff;
      h_side_ff.sx   <= g_sx_ff;
      h_side_ff.sy   <= g_sy_ff;
      h_side_ff.den  <= g_den_ff;
      h_side_ff.ovfx <= {2'b00, g_nx_ff} >= {g_den_ff, 16'd0};
      h_side_ff.ovfy <= {2'b00, g_ny_ff} >= {g_den_ff, 16'd0};
      h_dx_ff        <= '{rem: {3'd0, g_nx_ff[62:16]}, quo: '0, low: {g_nx_ff[15:0], 16'd0}};
      h_dy_ff        <= '{rem: {3'd0, g_ny_ff[62:16]}, quo: '0, low: {g_ny_ff[15:0], 16'd0}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= svld_ff[SQRT_STEPS-1];
         f_vld_ff <= e_vld_ff;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Divider chains for u and v: one quotient bit per cell.
   // ---------------------------------------------------------------------
   ucm_div_type  dx_in [DIV_STEPS];
   ucm_div_type  dx_ff [DIV_STEPS];
   ucm_div_type  dy_in [DIV_STEPS];
   ucm_div_type  dy_ff [DIV_STEPS];
   div_side_type dside_in [DIV_STEPS];
   div_side_type dside_ff [DIV_STEPS];
   logic         dvld_ff  [DIV_STEPS];

   genvar gd;
   generate
      for (gd = 0; gd < DIV_STEPS; gd++) begin : g_div
         if (gd == 0) begin : g_first
            assign dx_in[gd]    = h_dx_ff;
            assign dy_in[gd]    = h_dy_ff;
            assign dside_in[gd] = h_side_ff;
         end else begin : g_next
            assign dx_in[gd]    = dx_ff[gd-1];
            assign dy_in[gd]    = dy_ff[gd-1];
            assign dside_in[gd] = dside_ff[gd-1];
         end
         ucm_div_cell u_cell_x (
            .clock   (clock),
            .cell_in (dx_in[gd]),
            .den     (dside_in[gd].den),
            .cell_ff (dx_ff[gd])
         );
         ucm_div_cell u_cell_y (
            .clock   (clock),
            .cell_in (dy_in[gd]),
            .den     (dside_in[gd].den),
            .cell_ff (dy_ff[gd])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         dside_ff[k] <= dside_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            dvld_ff[k] <= 1'b0;
         end
      end else begin
         dvld_ff[0] <= h_vld_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            dvld_ff[k] <= dvld_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sign, center offset and saturation.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] finish_axis(input logic neg, input logic ovf,
                                               input logic [31:0] quo,
                                               input logic [31:0] center);
      logic signed [33:0] mag;
      logic signed [33:0] sum;
      logic [31:0]        res;
      mag = $signed({2'b00, quo});
      sum = (neg ? -mag : mag) + $signed({{2{center[31]}}, center});
      if (ovf) begin
         res = neg ? PIX_MIN : PIX_MAX;
      end else if (sum > $signed({2'b00, PIX_MAX})) begin
         res = PIX_MAX;
      end else if (sum < $signed({2'b11, PIX_MIN})) begin
         res = PIX_MIN;
      end else begin
         res = sum[31:0];
      end
      return res;
   endfunction

   div_side_type z_side;
   logic         out_vld_ff, out_ok_ff;
   logic [31:0]  out_u_ff, out_v_ff;
   logic [31:0]  out_u_in, out_v_in;

   assign z_side = dside_ff[DIV_STEPS-1];

   always_comb begin
      if (z_side.ok) begin
         out_u_in = finish_axis(z_side.sx, z_side.ovfx, dx_ff[DIV_STEPS-1].quo, center_x_ff);
         out_v_in = finish_axis(z_side.sy, z_side.ovfy, dy_ff[DIV_STEPS-1].quo, center_y_ff);
      end else begin
         out_u_in = INVALID_PIX;
         out_v_in = INVALID_PIX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dvld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      out_ok_ff <= z_side.ok;
      out_u_ff  <= out_u_in;
      out_v_ff  <= out_v_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_proj_valid = out_ok_ff;
   assign rsp_pixel_u    = out_u_ff;
   assign rsp_pixel_v    = out_v_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   // Every accepted point yields its result after the fixed latency.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("result missing after pipeline latency");

   // An invalid projection always reports minus one on both axes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_proj_valid |-> rsp_pixel_u == INVALID_PIX && rsp_pixel_v == INVALID_PIX)
      else $error("invalid projection with pixel values other than minus one");

   // A valid projection never feeds a non-positive denominator to the dividers.
   assert property (@(posedge clock) disable iff (reset)
      f_vld_ff && f_ok_ff |-> !f_den_ff[49] && (f_den_ff != '0))
      else $error("valid projection with non-positive denominator");

endmodule
